[hdl/tps_pkg.sv]
// tps_pkg: shared constants for the three-policy thread scheduler
// used by tps_div and three_policy_thread_scheduler; no dependencies
`default_nettype none
package tps_pkg;
  localparam int NTHR = 16;
  localparam int IDXW = $clog2(NTHR);
  localparam int CNTW = $clog2(NTHR + 1);
  localparam int TKW  = 16;
  localparam int TOTW = 20;
  localparam int PRIW = 8;
  localparam int DRW  = 16;
  localparam logic [TKW-1:0] TICKET_MAX = {TKW{1'b1}};

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_EXIT   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] MODE_RR   = 2'd0;
  localparam logic [1:0] MODE_LOT  = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic done;
    logic [TOTW:0] rem;
  } div_stat_t;
endpackage
`default_nettype wire

[hdl/tps_div.sv]
// tps_div: restoring remainder unit, one dividend bit per cycle
// depends on tps_pkg
`default_nettype none
module tps_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [tps_pkg::DRW-1:0]  dividend_i,
  input  wire logic [tps_pkg::TOTW:0]   divisor_i,
  output tps_pkg::div_stat_t            stat_o
);
  logic [tps_pkg::TOTW:0]  rem_q, rem_d, dsr_q, dsr_d, trial;
  logic [tps_pkg::DRW-1:0] dvd_q, dvd_d;
  logic [4:0]              cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[tps_pkg::TOTW-1:0], dvd_q[tps_pkg::DRW-1]};
    if (start_i) begin
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= dsr_q) ? trial - dsr_q : trial;
      dvd_d = {dvd_q[tps_pkg::DRW-2:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(tps_pkg::DRW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;
endmodule
`default_nettype wire

[hdl/three_policy_thread_scheduler.sv]
// three_policy_thread_scheduler: top level with thread table and scan sequencer
// depends on tps_pkg and tps_div
// Create, exit and unknown words go from idle straight to the output state. A tick
// scans the thread table one entry per cycle: round robin, priority (a second
// pass when the ran marks wrap), or lottery, which runs the remainder unit, then
// the ticket walk, then the skip of finished threads. A new word is taken only
// once the sequencer is back in idle.
`default_nettype none
module three_policy_thread_scheduler (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output wire logic       cfg_ready_o,
  input  wire logic [1:0] policy_mode_i,
  input  wire logic       in_valid_i,
  output wire logic       in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] new_priority_i,
  input  wire logic [15:0] new_tickets_i,
  input  wire logic [3:0] exit_index_i,
  input  wire logic [15:0] random_draw_i,
  output wire logic       out_valid_o,
  input  wire logic       out_ready_i,
  output wire logic [3:0] selected_thread_o,
  output wire logic       selection_valid_o,
  output wire logic [3:0] assigned_index_o,
  output wire logic       table_full_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RR   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_LOT  = 3'd3;
  localparam logic [2:0] S_PRI  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int IW = tps_pkg::IDXW;
  localparam int NT = tps_pkg::NTHR;

  logic [2:0]               st_q, st_d;
  logic [1:0]               mode_q;
  logic [IW-1:0]            cur_q, cur_d, idx_q, idx_d, who_q, who_d;
  logic [tps_pkg::CNTW-1:0] cnt_q, cnt_d;
  logic [NT-1:0]            fin_q, fin_d, ran_q, ran_d, live_mask;
  logic [tps_pkg::TOTW-1:0] tot_q, tot_d;
  logic [tps_pkg::TKW-1:0]  tk_q [NT];
  logic [tps_pkg::PRIW-1:0] pr_q [NT];
  logic                     tk_we, pr_we;
  logic [IW-1:0]            tk_wa;
  logic [tps_pkg::TKW-1:0]  tk_wd;
  logic [tps_pkg::TOTW+1:0] left_q, left_d, nleft;
  logic [tps_pkg::PRIW-1:0] best_q, best_d;
  logic                     found_q, found_d, cand;
  logic [IW-1:0]            last_idx, idx_inc;
  logic                     res_ld;
  logic [IW-1:0]            res_sel, res_asg, sel_q, asg_q;
  logic                     res_val, res_full, val_q, full_q, ov_q;
  logic                     div_start;
  tps_pkg::div_stat_t       div_st;

  tps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (random_draw_i),
    .divisor_i  ({1'b0, tot_q} + 21'd1),
    .stat_o     (div_st)
  );

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      live_mask[i] = (tps_pkg::CNTW'(i) < cnt_q) && !fin_q[i];
    end
  end

  assign last_idx = IW'(cnt_q - 1'b1);
  assign idx_inc  = (idx_q == last_idx) ? '0 : idx_q + 1'b1;
  assign nleft    = left_q - {{(tps_pkg::TOTW+2-tps_pkg::TKW){1'b0}}, tk_q[idx_q]};
  assign cand     = !fin_q[idx_q] && !ran_q[idx_q] && (!found_q || pr_q[idx_q] > best_q);

  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    who_d     = who_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    ran_d     = ran_q;
    tot_d     = tot_q;
    left_d    = left_q;
    best_d    = best_q;
    found_d   = found_q;
    tk_we     = 1'b0;
    pr_we     = 1'b0;
    tk_wa     = idx_q;
    tk_wd     = new_tickets_i;
    div_start = 1'b0;
    res_ld    = 1'b0;
    res_sel   = '0;
    res_val   = 1'b0;
    res_asg   = '0;
    res_full  = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = S_OUT;
          case (action_i)
            tps_pkg::ACT_TICK: begin
              if ((|live_mask) && mode_q != tps_pkg::MODE_NONE) begin
                case (mode_q)
                  tps_pkg::MODE_RR: begin
                    idx_d = ({1'b0, cur_q} + 1'b1 == cnt_q) ? '0 : cur_q + 1'b1;
                    st_d  = S_RR;
                  end
                  tps_pkg::MODE_LOT: begin
                    div_start = 1'b1;
                    st_d      = S_DIV;
                  end
                  default: begin
                    idx_d   = '0;
                    found_d = 1'b0;
                    st_d    = S_PRI;
                  end
                endcase
              end
            end
            tps_pkg::ACT_CREATE: begin
              if (cnt_q == tps_pkg::CNTW'(NT)) begin
                res_full = 1'b1;
              end else begin
                tk_we = 1'b1;
                pr_we = 1'b1;
                tk_wa = IW'(cnt_q);
                fin_d[IW'(cnt_q)] = 1'b0;
                ran_d[IW'(cnt_q)] = 1'b0;
                tot_d   = tot_q + {{(tps_pkg::TOTW-tps_pkg::TKW){1'b0}}, new_tickets_i};
                cnt_d   = cnt_q + 1'b1;
                res_asg = IW'(cnt_q);
              end
            end
            tps_pkg::ACT_EXIT: begin
              if ({1'b0, exit_index_i} < cnt_q) fin_d[exit_index_i] = 1'b1;
            end
            default: ;
          endcase
          res_ld = (st_d == S_OUT);
        end
      end
      S_RR: begin
        if (!fin_q[idx_q]) begin
          cur_d   = idx_q;
          res_sel = idx_q;
          res_val = 1'b1;
          res_ld  = 1'b1;
          st_d    = S_OUT;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          left_d = {1'b0, div_st.rem};
          idx_d  = '0;
          st_d   = S_LOT;
        end
      end
      S_LOT: begin
        left_d = nleft;
        if (nleft[tps_pkg::TOTW+1] || nleft == '0) begin
          st_d = S_RR;
        end else begin
          if (tk_q[idx_q] != tps_pkg::TICKET_MAX) begin
            tk_we = 1'b1;
            tk_wd = tk_q[idx_q] + 1'b1;
            tot_d = tot_q + 1'b1;
          end
          if (idx_q == last_idx) st_d = S_RR;
          else idx_d = idx_q + 1'b1;
        end
      end
      S_PRI: begin
        if (cand) begin
          found_d = 1'b1;
          best_d  = pr_q[idx_q];
          who_d   = idx_q;
        end
        if (idx_q == last_idx) begin
          if (found_d) begin
            ran_d[who_d] = 1'b1;
            cur_d   = who_d;
            res_sel = who_d;
            res_val = 1'b1;
            res_ld  = 1'b1;
            st_d    = S_OUT;
          end else begin
            ran_d   = '0;
            idx_d   = '0;
            found_d = 1'b0;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      mode_q <= tps_pkg::MODE_RR;
      cur_q  <= '0;
      cnt_q  <= '0;
      fin_q  <= '0;
      ran_q  <= '0;
      tot_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q  <= st_d;
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      fin_q <= fin_d;
      ran_q <= ran_d;
      tot_q <= tot_d;
      if (cfg_valid_i) mode_q <= policy_mode_i;
      if (st_q == S_OUT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // result words wait in a holding register until the out slot frees up
  logic [IW-1:0] hsel_q, hasg_q;
  logic          hval_q, hfull_q;

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    who_q   <= who_d;
    left_q  <= left_d;
    best_q  <= best_d;
    found_q <= found_d;
    if (tk_we) tk_q[tk_wa] <= tk_wd;
    if (pr_we) pr_q[IW'(cnt_q)] <= new_priority_i;
    if (res_ld) begin
      hsel_q  <= res_sel;
      hval_q  <= res_val;
      hasg_q  <= res_asg;
      hfull_q <= res_full;
    end
    if (st_q == S_OUT && (!ov_q || out_ready_i)) begin
      sel_q  <= hsel_q;
      val_q  <= hval_q;
      asg_q  <= hasg_q;
      full_q <= hfull_q;
    end
  end

  assign cfg_ready_o       = 1'b1;
  assign in_ready_o        = (st_q == S_IDLE);
  assign out_valid_o       = ov_q;
  assign selected_thread_o = sel_q;
  assign selection_valid_o = val_q;
  assign assigned_index_o  = asg_q;
  assign table_full_o      = full_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tps_pkg::CNTW'(NT)) else $error("thread count past table size");
  a_sel_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RR && !fin_q[idx_q]) |-> ({1'b0, idx_q} < cnt_q))
    else $error("selection outside created threads");
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i != tps_pkg::ACT_TICK) |=> (st_q == S_OUT))
    else $error("non-tick word did not finish at once");
endmodule
`default_nettype wire
